### src/mrb_pkg.sv
package mrb_pkg;

    localparam int unsigned MAX_COLS_DEF = 64;
    localparam int unsigned MAX_ROWS_DEF = 64;

    localparam int unsigned CFG_W = 7;
    localparam int unsigned AREA_W = 13;
    localparam logic [AREA_W-1:0] AREA_LIMIT = 13'h1fff;
    localparam logic [CFG_W-1:0] COLS_RESET = 7'd64;

    localparam int unsigned APB_AW = 3;
    localparam int unsigned APB_DW = 32;
    localparam logic [APB_AW-1:0] ADDR_COLS = 3'd0;

    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW = 2;

    typedef struct packed {
        logic set;
        logic last;
        logic row_end;
    } t_cell_flags;

    localparam int unsigned FLAG_W = $bits(t_cell_flags);

endpackage

### src/mrb_front.sv
module mrb_front #(
    parameter int unsigned MAX_COLS = 64,
    parameter int unsigned CW = 6
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [mrb_pkg::CFG_W-1:0]  i_cols,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic                       i_cell,
    input  logic                       i_last,
    input  logic                       i_full,
    output logic                       o_push,
    output mrb_pkg::t_cell_flags       o_flags,
    output logic [CW-1:0]              o_pos
);
    import mrb_pkg::*;

    localparam int unsigned NW = $clog2(MAX_COLS + 1);
    localparam int unsigned CNT_W = (NW > CFG_W) ? NW : CFG_W;

    logic [CW-1:0]    r_pos;
    logic [CW-1:0]    n_pos;
    logic [CNT_W-1:0] w_cols_raw;
    logic [CNT_W-1:0] w_cols;
    logic [CNT_W-1:0] w_pos_ext;
    logic [CNT_W-1:0] w_pos;
    logic [CNT_W-1:0] w_pos_inc;
    logic             w_row_end;

    // effective column count and clamped position
    always_comb begin
        w_cols_raw = CNT_W'(i_cols);
        if (w_cols_raw == '0) begin
            w_cols = CNT_W'(1);
        end else if (w_cols_raw > CNT_W'(MAX_COLS)) begin
            w_cols = CNT_W'(MAX_COLS);
        end else begin
            w_cols = w_cols_raw;
        end
        w_pos_ext = CNT_W'(r_pos);
        w_pos     = (w_pos_ext >= w_cols) ? (w_cols - CNT_W'(1)) : w_pos_ext;
        w_pos_inc = w_pos + CNT_W'(1);
        w_row_end = i_last || (w_pos_inc >= w_cols);
        n_pos     = w_row_end ? '0 : CW'(w_pos_inc);
    end

    assign o_ready         = !i_full;
    assign o_push          = i_valid && !i_full;
    assign o_flags.set     = i_cell;
    assign o_flags.last    = i_last;
    assign o_flags.row_end = w_row_end;
    assign o_pos           = CW'(w_pos);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (o_push) begin
            r_pos <= n_pos;
        end
    end

endmodule

### src/mrb_fifo.sv
module mrb_fifo #(
    parameter int unsigned W = 9
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);
    import mrb_pkg::*;

    logic [W-1:0]       r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr;
    logic [FIFO_AW-1:0] r_rd;
    logic [FIFO_AW:0]   r_cnt;
    logic               w_push;
    logic               w_pop;

    assign o_full  = (r_cnt == (FIFO_AW + 1)'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + FIFO_AW'(1);
            end
            if (w_pop) begin
                r_rd <= r_rd + FIFO_AW'(1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + (FIFO_AW + 1)'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - (FIFO_AW + 1)'(1);
            end
        end
    end

endmodule

### src/mrb_back.sv
module mrb_back #(
    parameter int unsigned MAX_COLS = 64,
    parameter int unsigned MAX_ROWS = 64,
    parameter int unsigned CW = 6,
    parameter int unsigned HW = 7
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_empty,
    output logic                        o_pop,
    input  mrb_pkg::t_cell_flags        i_flags,
    input  logic [CW-1:0]               i_pos,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [mrb_pkg::AREA_W-1:0]  o_area
);
    import mrb_pkg::*;

    localparam int unsigned NW = $clog2(MAX_COLS + 1);
    localparam int unsigned PW = HW + NW;
    localparam int unsigned XW = (PW > AREA_W) ? PW : AREA_W;
    localparam int unsigned SW = CW + HW;

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_UPD  = 3'd1;
    localparam logic [2:0] B_HRD  = 3'd2;
    localparam logic [2:0] B_CMP  = 3'd3;
    localparam logic [2:0] B_TOP  = 3'd4;
    localparam logic [2:0] B_FIN  = 3'd5;

    // height row and bar stack
    logic [HW-1:0] r_hmem [MAX_COLS];
    logic [SW-1:0] r_smem [MAX_COLS];
    logic [HW-1:0] r_hq;
    logic [SW-1:0] r_sq;

    logic [2:0]        r_state, n_state;
    t_cell_flags       r_flags, n_flags;
    logic [CW-1:0]     r_pos, n_pos;
    logic [NW-1:0]     r_n, n_n;
    logic [NW-1:0]     r_i, n_i;
    logic [NW-1:0]     r_depth, n_depth;
    logic [NW-1:0]     r_fill, n_fill;
    logic [HW-1:0]     r_top_h, n_top_h;
    logic [CW-1:0]     r_top_s, n_top_s;
    logic [CW-1:0]     r_lstart, n_lstart;
    logic              r_mul_v, n_mul_v;
    logic [PW-1:0]     r_mul_p, n_mul_p;
    logic [AREA_W-1:0] r_best, n_best;
    logic              r_out_v, n_out_v;
    logic [AREA_W-1:0] r_out_area, n_out_area;

    logic          w_h_we, w_h_re, w_s_we, w_s_re;
    logic [CW-1:0] w_h_waddr, w_h_raddr, w_s_waddr, w_s_raddr;
    logic [HW-1:0] w_h_wdata;
    logic [SW-1:0] w_s_wdata;
    logic [HW-1:0] w_hold, w_cur;
    logic [NW-1:0] w_pos_inc, w_width;
    logic [XW-1:0] w_prod_x;
    logic [AREA_W-1:0] w_sat;

    always_comb begin
        n_state    = r_state;
        n_flags    = r_flags;
        n_pos      = r_pos;
        n_n        = r_n;
        n_i        = r_i;
        n_depth    = r_depth;
        n_fill     = r_fill;
        n_top_h    = r_top_h;
        n_top_s    = r_top_s;
        n_lstart   = r_lstart;
        n_mul_v    = 1'b0;
        n_mul_p    = r_mul_p;
        n_best     = r_best;
        n_out_v    = r_out_v;
        n_out_area = r_out_area;
        o_pop      = 1'b0;
        w_h_we     = 1'b0;
        w_h_re     = 1'b0;
        w_s_we     = 1'b0;
        w_s_re     = 1'b0;
        w_h_waddr  = r_pos;
        w_h_raddr  = i_pos;
        w_s_waddr  = CW'(r_depth);
        w_s_raddr  = CW'(r_depth - NW'(2));
        w_s_wdata  = {r_lstart, r_hq};

        // entries past the fill count belong to an earlier matrix
        w_hold    = (NW'(r_pos) < r_fill) ? r_hq : '0;
        if (!r_flags.set) begin
            w_h_wdata = '0;
        end else if (w_hold < HW'(MAX_ROWS)) begin
            w_h_wdata = w_hold + HW'(1);
        end else begin
            w_h_wdata = HW'(MAX_ROWS);
        end
        w_pos_inc = NW'(r_pos) + NW'(1);
        w_cur     = (r_i < r_n) ? r_hq : '0;
        w_width   = r_i - NW'(r_top_s);

        // fold the previous product into the running best
        w_prod_x = XW'(r_mul_p);
        w_sat    = (w_prod_x > XW'(AREA_LIMIT)) ? AREA_LIMIT : AREA_W'(w_prod_x);
        if (r_mul_v && (w_sat > r_best)) begin
            n_best = w_sat;
        end

        if (r_out_v && i_ready) begin
            n_out_v = 1'b0;
        end

        case (r_state)
            B_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_flags = i_flags;
                    n_pos   = i_pos;
                    w_h_re  = 1'b1;
                    n_state = B_UPD;
                end
            end
            B_UPD: begin
                w_h_we = 1'b1;
                if (w_pos_inc > r_fill) begin
                    n_fill = w_pos_inc;
                end
                if (r_flags.row_end) begin
                    n_n     = w_pos_inc;
                    n_i     = '0;
                    n_depth = '0;
                    n_state = B_HRD;
                end else begin
                    n_state = B_IDLE;
                end
            end
            B_HRD: begin
                w_h_raddr = CW'(r_i);
                w_h_re    = (r_i < r_n);
                n_lstart  = CW'(r_i);
                n_state   = B_CMP;
            end
            B_CMP: begin
                if ((r_depth != '0) && (r_top_h >= w_cur)) begin
                    // pop: bar spans from its left edge up to the current column
                    n_mul_v  = 1'b1;
                    n_mul_p  = PW'(r_top_h) * PW'(w_width);
                    n_lstart = r_top_s;
                    n_depth  = r_depth - NW'(1);
                    if (r_depth > NW'(1)) begin
                        w_s_re  = 1'b1;
                        n_state = B_TOP;
                    end
                end else if (r_i < r_n) begin
                    w_s_we    = 1'b1;
                    w_s_wdata = {r_lstart, w_cur};
                    n_top_s   = r_lstart;
                    n_top_h   = w_cur;
                    n_depth   = r_depth + NW'(1);
                    n_i       = r_i + NW'(1);
                    n_state   = B_HRD;
                end else begin
                    n_state = B_FIN;
                end
            end
            B_TOP: begin
                n_top_s = r_sq[SW-1:HW];
                n_top_h = r_sq[HW-1:0];
                n_state = B_CMP;
            end
            B_FIN: begin
                if (!r_flags.last) begin
                    n_state = B_IDLE;
                end else if (!r_out_v || i_ready) begin
                    n_out_v    = 1'b1;
                    n_out_area = r_best;
                    n_best     = '0;
                    n_fill     = '0;
                    n_state    = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_h_we) begin
            r_hmem[w_h_waddr] <= w_h_wdata;
        end
        if (w_h_re) begin
            r_hq <= r_hmem[w_h_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_we) begin
            r_smem[w_s_waddr] <= w_s_wdata;
        end
        if (w_s_re) begin
            r_sq <= r_smem[w_s_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_depth <= '0;
            r_fill  <= '0;
            r_mul_v <= 1'b0;
            r_best  <= '0;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_depth <= n_depth;
            r_fill  <= n_fill;
            r_mul_v <= n_mul_v;
            r_best  <= n_best;
            r_out_v <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_flags    <= n_flags;
        r_pos      <= n_pos;
        r_n        <= n_n;
        r_i        <= n_i;
        r_top_h    <= n_top_h;
        r_top_s    <= n_top_s;
        r_lstart   <= n_lstart;
        r_mul_p    <= n_mul_p;
        r_out_area <= n_out_area;
    end

    assign o_valid = r_out_v;
    assign o_area  = r_out_area;

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= NW'(MAX_COLS))
        else $error("bar stack deeper than the row");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= NW'(MAX_COLS))
        else $error("fill count past the height row");

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_IDLE) |-> (r_depth == '0))
        else $error("bar stack not drained between rows");

    a_mul_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mul_v |-> ($past(r_state) == B_CMP))
        else $error("product without a pop");

    a_fin_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_FIN) |-> (!r_mul_v && (r_depth == '0)))
        else $error("row finished with work outstanding");

endmodule

### src/max_rectangle_binary_matrix.sv
// channel   | dir | tdata                        | tlast     | other
// s_axis    | in  | [0] cell_req, [7:1] zero     | last_cell | -
// m_axis    | out | [12:0] max_area, [15:13] 0   | -         | one item per matrix
// apb       | cfg | columns_in_use at 0x0        | -         | pready always high
//
// back end takes each cell through a height read (B_IDLE) and then a height write (B_UPD)
// a row end sweeps the columns: each push takes a height read and a compare, and each pop a compare
// and, while bars remain, a bar read (B_TOP) from the registered read of the single-port bar stack
// reset is a short synchronous pulse; the height row is cleared by a fill count, no sweep
// input stalls only when the 4-entry cell queue is full
// a matrix result waits in the output register while the next cells are taken
module max_rectangle_binary_matrix #(
    parameter int unsigned MAX_COLS = mrb_pkg::MAX_COLS_DEF,
    parameter int unsigned MAX_ROWS = mrb_pkg::MAX_ROWS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    input  logic [7:0]                   i_s_axis_tdata,   // [0] cell_req
    input  logic                         i_s_axis_tlast,
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    output logic [15:0]                  o_m_axis_tdata,   // [12:0] max_area
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mrb_pkg::APB_AW-1:0]   paddr,
    input  logic [mrb_pkg::APB_DW-1:0]   pwdata,
    output logic [mrb_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);
    import mrb_pkg::*;

    localparam int unsigned CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int unsigned HW = $clog2(MAX_ROWS + 1);
    localparam int unsigned QW = FLAG_W + CW;

    logic [CFG_W-1:0]  r_cols;
    logic              w_push;
    logic              w_full;
    t_cell_flags       w_push_flags;
    logic [CW-1:0]     w_push_pos;
    logic [QW-1:0]     w_q_out;
    logic              w_pop;
    logic              w_empty;
    t_cell_flags       w_pop_flags;
    logic [CW-1:0]     w_pop_pos;
    logic [AREA_W-1:0] w_area;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_COLS) ? APB_DW'(r_cols) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= COLS_RESET;
        end else if (psel && penable && pwrite && pready && (paddr == ADDR_COLS)) begin
            r_cols <= pwdata[CFG_W-1:0];
        end
    end

    mrb_front #(
        .MAX_COLS (MAX_COLS),
        .CW       (CW)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cols  (r_cols),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_cell  (i_s_axis_tdata[0]),
        .i_last  (i_s_axis_tlast),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_flags (w_push_flags),
        .o_pos   (w_push_pos)
    );

    mrb_fifo #(
        .W (QW)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_push_flags, w_push_pos}),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_q_out),
        .o_empty (w_empty)
    );

    assign w_pop_flags = t_cell_flags'(w_q_out[QW-1:CW]);
    assign w_pop_pos   = w_q_out[CW-1:0];

    mrb_back #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS),
        .CW       (CW),
        .HW       (HW)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .i_flags (w_pop_flags),
        .i_pos   (w_pop_pos),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_area  (w_area)
    );

    assign o_m_axis_tdata = 16'(w_area);

endmodule
